FILE: sv/thermistor_lut_interpolator_macros.svh
// Assertion helpers for the thermistor interpolator.
`ifndef THERMISTOR_LUT_INTERPOLATOR_MACROS_SVH
`define THERMISTOR_LUT_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TLI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tli: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TLI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tli: next-cycle check failed");

`endif

FILE: sv/tli_pkg.sv
package tli_pkg;

    localparam int TABLE_ENTRIES = 17;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int VOLT_W        = 22;
    localparam int TEMP_W        = 19;
    localparam int Q_W           = TEMP_W;
    localparam int PROD_W        = TEMP_W + VOLT_W;
    localparam int CNT_W         = $clog2(Q_W);

    typedef enum logic [2:0] {
        RES_HOLD,
        RES_COLD,
        RES_HOT,
        RES_T1,
        RES_INTERP
    } res_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     search_step;
        logic     load_seg;
        logic     mult;
        logic     div_step;
        res_sel_t res_sel;
        logic     load_out;
    } tli_cmd_t;

    typedef struct packed {
        logic above_first;
        logic below_last;
        logic seg_found;
        logic seg_last;
        logic vdiff_zero;
    } tli_status_t;

    // Divider voltages, floor(3300000*R/(10000+R)), descending.
    function automatic logic [VOLT_W-1:0] lut_v(input int unsigned idx);
        logic [VOLT_W-1:0] v;
        case (idx)
            0:       v = 22'd3121814;
            1:       v = 22'd2524514;
            2:       v = 22'd2195286;
            3:       v = 22'd1832550;
            4:       v = 22'd1650000;
            5:       v = 22'd1472656;
            6:       v = 22'd1304233;
            7:       v = 22'd1147358;
            8:       v = 22'd1003868;
            9:       v = 22'd874421;
            10:      v = 22'd759388;
            11:      v = 22'd657886;
            12:      v = 22'd569116;
            13:      v = 22'd368230;
            14:      v = 22'd209244;
            15:      v = 22'd58986;
            default: v = 22'd20659;
        endcase
        return v;
    endfunction

    function automatic logic signed [TEMP_W-1:0] lut_t(input int unsigned idx);
        logic signed [TEMP_W-1:0] t;
        case (idx)
            0:       t = -19'sd30000;
            1:       t = 19'sd0;
            2:       t = 19'sd10000;
            3:       t = 19'sd20000;
            4:       t = 19'sd25000;
            5:       t = 19'sd30000;
            6:       t = 19'sd35000;
            7:       t = 19'sd40000;
            8:       t = 19'sd45000;
            9:       t = 19'sd50000;
            10:      t = 19'sd55000;
            11:      t = 19'sd60000;
            12:      t = 19'sd65000;
            13:      t = 19'sd80000;
            14:      t = 19'sd100000;
            15:      t = 19'sd150000;
            default: t = 19'sd200000;
        endcase
        return t;
    endfunction

endpackage

FILE: sv/thermistor_lut_interpolator.sv
// Thermistor voltage (uV) to temperature (milli-Celsius) by piecewise-linear
// interpolation over a fixed 17-point table. One word is in flight at a time:
// in_ready is high only while the block is idle, but a finished result may
// sit in the output register while the next word is taken. A word that
// clamps at either end of the table goes straight to the output; otherwise
// the segment search walks the segment index k (0 to 15), comparing one
// table entry per cycle, then a multiply step and a restoring divider (one
// quotient bit per cycle) set the rest. The table is constant logic;
// nothing to initialize after reset.
module thermistor_lut_interpolator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [tli_pkg::VOLT_W-1:0]        sense_uv,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [tli_pkg::TEMP_W-1:0] temp_mc,
    output logic                              clamped
);
    import tli_pkg::*;

    `include "thermistor_lut_interpolator_macros.svh"

    tli_cmd_t    cmd;
    tli_status_t status;

    tli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tli_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .sense_uv (sense_uv),
        .temp_mc  (temp_mc),
        .clamped  (clamped)
    );

    // a pending result is never overwritten
    `TLI_ASSERT_NOW(a_no_overwrite, cmd.load_out, !out_valid || out_ready)
    // one word at a time
    `TLI_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // a clamped word carries one of the two end temperatures
    `TLI_ASSERT_NOW(a_clamp_value, out_valid && clamped,
        temp_mc == lut_t(0) || temp_mc == lut_t(TABLE_ENTRIES - 1))
    // an interpolated word stays within the table's temperature span
    `TLI_ASSERT_NOW(a_interp_range, out_valid && !clamped,
        temp_mc >= lut_t(0) && temp_mc <= lut_t(TABLE_ENTRIES - 1))

endmodule

FILE: sv/tli_dp.sv
module tli_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tli_pkg::tli_cmd_t                 cmd,
    output tli_pkg::tli_status_t              status,
    input  logic [tli_pkg::VOLT_W-1:0]        sense_uv,
    output logic signed [tli_pkg::TEMP_W-1:0] temp_mc,
    output logic                              clamped
);
    import tli_pkg::*;

    localparam logic [VOLT_W-1:0]        V_FIRST = lut_v(0);
    localparam logic [VOLT_W-1:0]        V_LAST  = lut_v(TABLE_ENTRIES - 1);
    localparam logic signed [TEMP_W-1:0] T_COLD  = lut_t(0);
    localparam logic signed [TEMP_W-1:0] T_HOT   = lut_t(TABLE_ENTRIES - 1);

    logic [VOLT_W-1:0]        v_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [TEMP_W-1:0] t1_reg;
    logic                     neg_reg;
    logic [TEMP_W-1:0]        dtmag_reg;
    logic [VOLT_W-1:0]        mdiff_reg;
    logic [VOLT_W-1:0]        vdiff_reg;
    logic [VOLT_W-1:0]        rem_reg;
    logic [Q_W-1:0]           q_reg;
    logic signed [TEMP_W-1:0] res_temp_reg;
    logic                     res_clamp_reg;
    logic signed [TEMP_W-1:0] out_temp_reg;
    logic                     out_clamp_reg;

    logic [VOLT_W-1:0]        v_hi;
    logic [VOLT_W-1:0]        v_lo;
    logic signed [TEMP_W-1:0] t_hi;
    logic signed [TEMP_W-1:0] t_lo;
    logic signed [TEMP_W:0]   dt;
    logic [TEMP_W:0]          dt_abs;
    logic [PROD_W-1:0]        prod;
    logic [VOLT_W:0]          trial;
    logic [VOLT_W:0]          trial_diff;
    logic                     trial_ge;
    logic signed [TEMP_W+1:0] q_signed;
    logic signed [TEMP_W+1:0] t_sum;

    always_comb
    begin
        v_hi = lut_v(int'(idx_reg));
        v_lo = lut_v(int'(idx_reg) + 1);
        t_hi = lut_t(int'(idx_reg));
        t_lo = lut_t(int'(idx_reg) + 1);
        dt     = (TEMP_W+1)'(t_lo) - (TEMP_W+1)'(t_hi);
        dt_abs = dt[TEMP_W] ? (TEMP_W+1)'(-dt) : (TEMP_W+1)'(dt);
        prod   = PROD_W'(dtmag_reg) * PROD_W'(mdiff_reg);

        // one restoring step: shift in next dividend bit, subtract if it fits
        trial      = {rem_reg, q_reg[Q_W-1]};
        trial_ge   = trial >= {1'b0, vdiff_reg};
        trial_diff = trial - {1'b0, vdiff_reg};

        // floor division: negative quotient with remainder rounds down
        q_signed = (TEMP_W+2)'(signed'({2'b00, q_reg}));
        if (neg_reg)
        begin
            q_signed = -q_signed - ((rem_reg != '0) ? (TEMP_W+2)'(1) : (TEMP_W+2)'(0));
        end
        t_sum = (TEMP_W+2)'(t1_reg) + q_signed;

        status.above_first = v_reg >= V_FIRST;
        status.below_last  = v_reg <= V_LAST;
        status.seg_found   = v_reg >= v_lo;
        status.seg_last    = idx_reg == IDX_W'(TABLE_ENTRIES - 2);
        status.vdiff_zero  = vdiff_reg == '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            v_reg <= sense_uv;
        end
        if (cmd.load_seg)
        begin
            t1_reg    <= t_hi;
            neg_reg   <= dt[TEMP_W];
            dtmag_reg <= dt_abs[TEMP_W-1:0];
            mdiff_reg <= v_hi - v_reg;
            vdiff_reg <= v_hi - v_lo;
        end
        if (cmd.mult)
        begin
            rem_reg <= prod[PROD_W-1:Q_W];
            q_reg   <= prod[Q_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_diff[VOLT_W-1:0] : trial[VOLT_W-1:0];
            q_reg   <= {q_reg[Q_W-2:0], trial_ge};
        end
        case (cmd.res_sel)
            RES_COLD:
            begin
                res_temp_reg  <= T_COLD;
                res_clamp_reg <= 1'b1;
            end
            RES_HOT:
            begin
                res_temp_reg  <= T_HOT;
                res_clamp_reg <= 1'b1;
            end
            RES_T1:
            begin
                res_temp_reg  <= t1_reg;
                res_clamp_reg <= 1'b0;
            end
            RES_INTERP:
            begin
                res_temp_reg  <= t_sum[TEMP_W-1:0];
                res_clamp_reg <= 1'b0;
            end
            default:
            begin
            end
        endcase
        if (cmd.load_out)
        begin
            out_temp_reg  <= res_temp_reg;
            out_clamp_reg <= res_clamp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.load_in)
        begin
            idx_reg <= '0;
        end
        else if (cmd.search_step)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    assign temp_mc = out_temp_reg;
    assign clamped = out_clamp_reg;

endmodule

FILE: sv/tli_ctrl.sv
module tli_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  tli_pkg::tli_status_t status,
    output tli_pkg::tli_cmd_t    cmd
);
    import tli_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_MUL,
        S_DIV,
        S_FIN,
        S_OUT
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              slot_free;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        cmd.res_sel    = RES_HOLD;
        slot_free      = !out_valid_reg || out_ready;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.above_first)
                begin
                    cmd.res_sel = RES_COLD;
                    state_next  = S_OUT;
                end
                else if (status.below_last)
                begin
                    cmd.res_sel = RES_HOT;
                    state_next  = S_OUT;
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (status.seg_found)
                begin
                    cmd.load_seg = 1'b1;
                    state_next   = S_MUL;
                end
                else if (status.seg_last)
                begin
                    // no bounding segment: falls back to the hot end
                    cmd.res_sel = RES_HOT;
                    state_next  = S_OUT;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                end
            end
            S_MUL:
            begin
                if (status.vdiff_zero)
                begin
                    cmd.res_sel = RES_T1;
                    state_next  = S_OUT;
                end
                else
                begin
                    cmd.mult   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(Q_W - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.res_sel = RES_INTERP;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

endmodule
